FILE: hdl/vpf_pkg.sv
// ----------------------------------------------------------------------------
// vpf_pkg
// Types and register codes shared by the velocity pid loop and its divider.
// ----------------------------------------------------------------------------
package vpf_pkg;

  typedef struct packed {
    logic signed [15:0] measured_velocity;
    logic        [15:0] elapsed_time;
    logic               run_enable;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] throttle_command;
    logic               updated;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned RegIdxW  = 3;

  localparam logic [RegIdxW-1:0] REG_KP  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_KD  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_KI  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_KF  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_TGT = 3'd4;

  localparam int unsigned DivNumW = 33;
  localparam int unsigned DivDenW = 16;

endpackage

FILE: hdl/vpf_div.sv
// ----------------------------------------------------------------------------
// vpf_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vpf_div
  import vpf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DivNumW-1:0] dividend,
  input  logic [DivDenW-1:0] divisor,
  output logic [DivNumW-1:0] quotient,
  output div_stat_t          stat
);

  localparam int unsigned CntW = $clog2(DivNumW + 1);

  logic [DivDenW-1:0] rem_r;
  logic [DivNumW-1:0] quo_r;
  logic [DivDenW-1:0] den_r;
  logic [CntW-1:0]    cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   shifted;

  assign shifted = {rem_r, quo_r[DivNumW-1]};
  assign trial   = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r & ~start & (cnt_r == CntW'(1));
      if (start) begin
        rem_r  <= '0;
        quo_r  <= dividend;
        den_r  <= divisor;
        cnt_r  <= CntW'(DivNumW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!trial[DivDenW]) begin
          rem_r <= trial[DivDenW-1:0];
          quo_r <= {quo_r[DivNumW-2:0], 1'b1};
        end else begin
          rem_r <= shifted[DivDenW-1:0];
          quo_r <= {quo_r[DivNumW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: hdl/velocity_pid_feedforward.sv
// ----------------------------------------------------------------------------
// velocity_pid_feedforward
// Velocity pid loop with feedforward on Q8.8 fixed point samples.
// ----------------------------------------------------------------------------
// usage
//   in_ channel: one velocity sample per transfer (measured velocity, elapsed
//   time, run enable). in_stall is high while a sample is being worked on.
//   out_ channel: exactly one result per sample, held in an output register
//   until the receiver takes it; a stalled result keeps its value.
//   cfg_ port: apb-style register writes/reads, gains and target at 4*i;
//   write only while the block is idle.
// sample flow
//   an updating sample goes through the transfer, 33 divider steps (one
//   quotient bit per cycle), the divider handoff, the shared 32x16
//   multiplier and accumulator, then saturate and output load. a frozen
//   or zero-time sample goes straight to output load. one sample is in flight at a time.
// reset
//   gains and target return to their defaults, loop state clears to zero.
// receiver stall
//   a finished result waits in the output register; the next sample is taken
//   meanwhile, and its result waits until the register is free.
// ----------------------------------------------------------------------------
module velocity_pid_feedforward
  import vpf_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_SAT,
    S_OUT
  } state_t;

  localparam logic [2:0] STEP_P    = 3'd0;
  localparam logic [2:0] STEP_D    = 3'd1;
  localparam logic [2:0] STEP_I    = 3'd2;
  localparam logic [2:0] STEP_F    = 3'd3;
  localparam logic [2:0] STEP_LAST = 3'd4;

  // configuration registers
  logic signed [15:0] kp_r, kd_r, ki_r, kf_r, tgt_r;
  logic               cfg_wr;
  logic [RegIdxW-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CfgAddrW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= 16'sd256;
      kd_r  <= 16'sd0;
      ki_r  <= 16'sd0;
      kf_r  <= 16'sd256;
      tgt_r <= 16'sd512;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KP:  kp_r  <= cfg_pwdata[15:0];
        REG_KD:  kd_r  <= cfg_pwdata[15:0];
        REG_KI:  ki_r  <= cfg_pwdata[15:0];
        REG_KF:  kf_r  <= cfg_pwdata[15:0];
        REG_TGT: tgt_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KP:  cfg_prdata = {{16{kp_r[15]}}, kp_r};
      REG_KD:  cfg_prdata = {{16{kd_r[15]}}, kd_r};
      REG_KI:  cfg_prdata = {{16{ki_r[15]}}, ki_r};
      REG_KF:  cfg_prdata = {{16{kf_r[15]}}, kf_r};
      REG_TGT: cfg_prdata = {{16{tgt_r[15]}}, tgt_r};
      default: cfg_prdata = '0;
    endcase
  end

  // loop state and working registers
  state_t             state_r;
  logic signed [16:0] last_err_r;
  logic signed [31:0] integ_r;
  logic signed [15:0] last_thr_r;
  logic signed [16:0] err_r;
  logic signed [31:0] integ_new_r;
  logic signed [31:0] d_r;
  logic               neg_r;
  logic [2:0]         step_r;
  logic signed [47:0] prod_r;
  logic signed [49:0] acc_r;
  logic               upd_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // sample transfer arithmetic
  logic               in_xfer;
  logic               run_upd;
  logic signed [16:0] err_nxt;
  logic signed [17:0] diff;
  logic [17:0]        diff_mag;
  logic [DivNumW-1:0] dividend;
  logic signed [32:0] isum;
  logic signed [31:0] integ_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid & ~in_stall;
  assign run_upd  = in_data.run_enable & (in_data.elapsed_time != '0);

  assign err_nxt  = {tgt_r[15], tgt_r}
                  - {in_data.measured_velocity[15], in_data.measured_velocity};
  assign diff     = {last_err_r[16], last_err_r} - {err_nxt[16], err_nxt};
  assign diff_mag = diff[17] ? 18'(-diff) : 18'(diff);
  assign dividend = {diff_mag[16:0], 16'b0};
  assign isum     = {integ_r[31], integ_r} + {{16{err_nxt[16]}}, err_nxt};

  always_comb begin
    if (isum[32] != isum[31]) begin
      integ_nxt = isum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      integ_nxt = isum[31:0];
    end
  end

  // divider
  logic [DivNumW-1:0] div_quo;
  div_stat_t          div_stat;
  logic signed [31:0] d_nxt;

  vpf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_xfer & run_upd),
    .dividend (dividend),
    .divisor  (in_data.elapsed_time),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  always_comb begin
    if (neg_r) begin
      if (div_quo > 33'h0_8000_0000) begin
        d_nxt = 32'sh8000_0000;
      end else begin
        d_nxt = -div_quo[31:0];
      end
    end else begin
      if (div_quo[32] | div_quo[31]) begin
        d_nxt = 32'sh7fff_ffff;
      end else begin
        d_nxt = div_quo[31:0];
      end
    end
  end

  // shared multiplier
  logic signed [31:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [47:0] prod_nxt;

  always_comb begin
    case (step_r)
      STEP_P: begin
        mul_a = {{15{err_r[16]}}, err_r};
        mul_b = kp_r;
      end
      STEP_D: begin
        mul_a = d_r;
        mul_b = kd_r;
      end
      STEP_I: begin
        mul_a = integ_new_r;
        mul_b = ki_r;
      end
      STEP_F: begin
        mul_a = {{16{tgt_r[15]}}, tgt_r};
        mul_b = kf_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // final scaling and saturation
  logic signed [49:0] acc_sh;
  logic signed [15:0] thr_nxt;

  assign acc_sh = acc_r >>> FRACTION_BITS;

  always_comb begin
    if (acc_sh > 50'sd32767) begin
      thr_nxt = 16'sh7fff;
    end else if (acc_sh < -50'sd32768) begin
      thr_nxt = 16'sh8000;
    end else begin
      thr_nxt = acc_sh[15:0];
    end
  end

  logic out_free;
  assign out_free = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_err_r  <= '0;
      integ_r     <= '0;
      last_thr_r  <= '0;
      out_valid_r <= 1'b0;
      step_r      <= STEP_P;
      upd_r       <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            err_r       <= err_nxt;
            integ_new_r <= integ_nxt;
            neg_r       <= diff[17];
            upd_r       <= run_upd;
            state_r     <= run_upd ? S_DIV : S_OUT;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            d_r     <= d_nxt;
            acc_r   <= '0;
            step_r  <= STEP_P;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= prod_nxt;
          if (step_r != STEP_P) begin
            acc_r <= acc_r + {{2{prod_r[47]}}, prod_r};
          end
          if (step_r == STEP_LAST) begin
            state_r <= S_SAT;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_SAT: begin
          last_err_r <= err_r;
          integ_r    <= integ_new_r;
          last_thr_r <= thr_nxt;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_data_r.throttle_command <= last_thr_r;
            out_data_r.updated          <= upd_r;
            out_valid_r                 <= 1'b1;
            state_r                     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != S_IDLE)
    else $error("sample transfer did not start work");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside divide state");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !div_stat.busy)
    else $error("divider busy while idle");
`endif

endmodule

FILE: bench/tb_velocity_pid_feedforward.sv
// ----------------------------------------------------------------------------
// tb_velocity_pid_feedforward
// Self-checking bench for the velocity pid loop with feedforward. Samples go
// in over the valid/stall input channel, gains and target are set through the
// apb-style port between phases, and every result is compared per field with
// a bit-true model of the loop kept in a small scoreboard class. Directed
// samples cover field extremes, frozen and zero-time samples and saturation;
// random phases follow with random gains, idle gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_velocity_pid_feedforward
  import vpf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned REG_COUNT   = 5;
  localparam int          WATCH_LIMIT = 4000;
  localparam int          SETTLE_CYC  = 60;
  localparam int          PHASES      = 7;
  localparam int          PHASE_ITEMS = 270;

  class throttle_predictor;
    logic signed [15:0] gain_p, gain_d, gain_i, gain_f, target;
    logic signed [16:0] prev_err;
    logic signed [31:0] err_sum;
    logic signed [15:0] held_throttle;
    out_item_t          expected_cmd_q[$];
    int                 mismatches;

    function new();
      gain_p        = 16'sd256;
      gain_d        = 16'sd0;
      gain_i        = 16'sd0;
      gain_f        = 16'sd256;
      target        = 16'sd512;
      prev_err      = '0;
      err_sum       = '0;
      held_throttle = '0;
      mismatches    = 0;
    endfunction

    function void report(string what, longint exp_v, longint got_v);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
      end
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_reg(logic [RegIdxW-1:0] idx, logic [31:0] val);
      case (idx)
        REG_KP:  gain_p = val[15:0];
        REG_KD:  gain_d = val[15:0];
        REG_KI:  gain_i = val[15:0];
        REG_KF:  gain_f = val[15:0];
        REG_TGT: target = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] reg_value(logic [RegIdxW-1:0] idx);
      case (idx)
        REG_KP:  return gain_p;
        REG_KD:  return gain_d;
        REG_KI:  return gain_i;
        REG_KF:  return gain_f;
        default: return target;
      endcase
    endfunction

    function int pending();
      return expected_cmd_q.size();
    endfunction

    function void take_sample(in_item_t s);
      longint    meas, t, e, d, acc, sum;
      out_item_t r;
      meas = $signed(s.measured_velocity);
      t    = s.elapsed_time;
      if (s.run_enable && s.elapsed_time != 16'd0) begin
        e   = longint'(target) - meas;
        d   = ((longint'(prev_err) - e) * 64'sd65536) / t;
        d   = clip(d, -64'sd2147483648, 64'sd2147483647);
        acc = clip(longint'(err_sum) + e, -64'sd2147483648, 64'sd2147483647);
        sum = longint'(gain_p) * e + longint'(gain_d) * d
            + longint'(gain_i) * acc + longint'(gain_f) * longint'(target);
        sum = clip(sum >>> FRAC_BITS, -64'sd32768, 64'sd32767);
        prev_err      = e[16:0];
        err_sum       = acc[31:0];
        held_throttle = sum[15:0];
        r.updated     = 1'b1;
      end else begin
        r.updated = 1'b0;
      end
      r.throttle_command = held_throttle;
      expected_cmd_q.push_back(r);
    endfunction

    function void check_command(out_item_t got);
      out_item_t exp_r;
      if (expected_cmd_q.size() == 0) begin
        report("unexpected result, throttle", 0, got.throttle_command);
        return;
      end
      exp_r = expected_cmd_q.pop_front();
      if (got.throttle_command !== exp_r.throttle_command) begin
        report("throttle_command", exp_r.throttle_command, got.throttle_command);
      end
      if (got.updated !== exp_r.updated) begin
        report("updated", exp_r.updated, got.updated);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  throttle_predictor   model;
  bit                  no_idle = 1'b0;

  velocity_pid_feedforward #(
    .FRACTION_BITS(FRAC_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic in_item_t sample(int meas, int unsigned dt, bit en);
    in_item_t s;
    s.measured_velocity = meas[15:0];
    s.elapsed_time      = dt[15:0];
    s.run_enable        = en;
    return s;
  endfunction

  function automatic logic [15:0] rand_gain();
    int v;
    case ($urandom_range(0, 9))
      0:       v = -32768;
      1:       v = 32767;
      2, 3, 4: v = int'($urandom_range(0, 1024)) - 512;
      5:       v = int'($urandom_range(0, 64)) - 32;
      default: v = int'($urandom_range(0, 65535));
    endcase
    return v[15:0];
  endfunction

  function automatic in_item_t rand_sample();
    int          meas;
    int unsigned dt;
    case ($urandom_range(0, 9))
      0:       meas = -32768;
      1:       meas = 32767;
      2, 3, 4: meas = int'(model.target) + int'($urandom_range(0, 64)) - 32;
      default: meas = int'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 11))
      0:       dt = 0;
      1, 2:    dt = $urandom_range(1, 16);
      3:       dt = 65535;
      default: dt = $urandom_range(1, 65535);
    endcase
    return sample(meas, dt, $urandom_range(0, 9) != 0);
  endfunction

  task automatic send(in_item_t s);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    model.take_sample(s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(logic [RegIdxW-1:0] idx, logic [15:0] val);
    logic [31:0] word;
    word = {16'($urandom_range(0, 65535)), val};
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    model.set_reg(idx, word);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_registers();
    logic [RegIdxW-1:0] idx;
    for (int k = 0; k < REG_COUNT; k++) begin
      idx = k[RegIdxW-1:0];
      cfg_psel    <= 1'b1;
      cfg_pwrite  <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_paddr   <= {idx, 2'b00};
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (cfg_pready !== 1'b1);
      if (cfg_prdata[15:0] !== model.reg_value(idx)) begin
        model.report("register readback", model.reg_value(idx), cfg_prdata[15:0]);
      end
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic set_all(logic [15:0] kp, logic [15:0] kd, logic [15:0] ki,
                         logic [15:0] kf, logic [15:0] tgt);
    cfg_write(REG_KP, kp);
    cfg_write(REG_KD, kd);
    cfg_write(REG_KI, ki);
    cfg_write(REG_KF, kf);
    cfg_write(REG_TGT, tgt);
    cfg_write(RegIdxW'($urandom_range(REG_COUNT, 7)), 16'($urandom_range(0, 65535)));
    check_registers();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      model.check_command(out_data);
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 15)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCH_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    model       = new();
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gains and target
    check_registers();
    send(sample(0, 1, 1'b1));
    send(sample(32767, 65535, 1'b1));
    send(sample(-32768, 1, 1'b1));
    send(sample(0, 0, 1'b1));
    send(sample(100, 500, 1'b0));
    send(sample(-32768, 0, 1'b0));
    send(sample(32767, 1, 1'b1));
    send(sample(1234, 65535, 1'b1));
    drain();

    // largest gains, derivative and throttle saturation
    set_all(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send(sample(-32768, 1, 1'b1));
    send(sample(32767, 1, 1'b1));
    send(sample(32767, 65535, 1'b1));
    send(sample(-32768, 65535, 1'b0));
    send(sample(0, 0, 1'b1));
    send(sample(-32768, 1, 1'b1));
    send(sample(0, 2, 1'b1));
    drain();

    set_all(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send(sample(32767, 1, 1'b1));
    send(sample(-32768, 1, 1'b1));
    send(sample(-32768, 65535, 1'b1));
    send(sample(0, 3, 1'b0));
    send(sample(-1, 40000, 1'b1));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_all(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain());
      if (ph == PHASES - 1) no_idle = 1'b1;
      repeat (PHASE_ITEMS) send(rand_sample());
      drain();
    end

    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
